>>> hdl/ttyop_pkg.sv
// Package with shared types, character codes and escape tables for the tty output post-processor.
`timescale 1ns / 1ps

package ttyop_pkg;

  // Character codes.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DEL     = 8'h7F;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [7:0] DELAY_MARK = 8'h80;

  // Delay amounts in ticks.
  localparam logic [6:0] DLY_BS       = 7'd2;
  localparam logic [6:0] DLY_TAB      = 7'd2;
  localparam logic [6:0] DLY_NL       = 7'd5;
  localparam logic [6:0] DLY_CR_SHORT = 7'd5;
  localparam logic [6:0] DLY_CR_LONG  = 7'd9;
  localparam logic [6:0] DLY_CR_BASE  = 7'd3;
  localparam logic [6:0] DLY_CR_MIN   = 7'd6;
  localparam logic [6:0] DLY_PAGE     = 7'h7F;
  localparam logic [6:0] DLY_FILL_MAX = 7'd32;
  localparam logic [6:0] DLY_ONE_FILL = 7'd3;
  localparam logic [3:0] TAB_MIN_DLY  = 4'd5;
  localparam logic [3:0] TAB_STOP     = 4'd8;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_POST_ENABLE  = 3'd0;
  localparam logic [2:0] REG_CASE_MODE    = 3'd1;
  localparam logic [2:0] REG_NEWLINE_MODE = 3'd2;
  localparam logic [2:0] REG_FILL_MODE    = 3'd3;
  localparam logic [2:0] REG_CR_DELAY     = 3'd4;
  localparam logic [2:0] REG_TAB_DELAY    = 3'd5;
  localparam logic [2:0] REG_MISC_DELAYS  = 3'd6;

  // Delay kinds for carriage return and tab.
  localparam logic [1:0] CRD_NONE   = 2'd0;
  localparam logic [1:0] CRD_COLUMN = 2'd1;
  localparam logic [1:0] CRD_SHORT  = 2'd2;
  localparam logic [1:0] CRD_LONG   = 2'd3;
  localparam logic [1:0] TABD_NONE   = 2'd0;
  localparam logic [1:0] TABD_COLUMN = 2'd1;
  localparam logic [1:0] TABD_FIXED  = 2'd2;
  localparam logic [1:0] TABD_EXPAND = 2'd3;

  // Descriptor queue between the front and back ends.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;   // pointers wrap naturally at Q_DEPTH
  localparam int Q_CNT_W = 2;

  typedef struct packed {
    logic       post_enable;
    logic [1:0] case_mode;
    logic [3:0] newline_mode;
    logic [1:0] fill_mode;
    logic [1:0] cr_delay;
    logic [1:0] tab_delay;
    logic [3:0] misc_delays;
  } ttyop_cfg_t;

  // One input byte's output run: optional prefix byte, a repeated main byte,
  // and up to two trailing delay bytes.
  typedef struct packed {
    logic       pre_en;
    logic [7:0] pre_byte;
    logic [7:0] main_byte;
    logic [2:0] main_rep;   // repeat count minus one
    logic [1:0] suf_cnt;
    logic [7:0] suf0;
    logic [7:0] suf1;
  } ttyop_desc_t;

  // Upper-case-only terminal escapes: the character that follows the backslash.
  function automatic logic esc_hit(input logic [7:0] c);
    logic hit;
    case (c)
      8'h7B, 8'h7D, 8'h7C, 8'h7E, 8'h60, 8'h5C: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [7:0] esc_map(input logic [7:0] c);
    logic [7:0] m;
    case (c)
      8'h7B:   m = 8'h28;
      8'h7D:   m = 8'h29;
      8'h7C:   m = 8'h21;
      8'h7E:   m = 8'h5E;
      8'h60:   m = 8'h27;
      8'h5C:   m = 8'h5C;
      default: m = c;
    endcase
    return m;
  endfunction

endpackage

>>> hdl/tty_output_postprocessor_top.sv
// Top level of the tty output post-processor: configuration, front end, queue, back end.
//
// Usage: each input transaction (in_valid high, in_stall low) carries one byte
// headed for a terminal. The block returns the bytes to send, one output
// transaction per byte, with out_last set on the final byte of each input.
// A carriage return at column zero may be suppressed entirely, in which case
// that input yields no output transaction at all.
// With the queue and output register empty, an accepted input is written into
// the queue first and its first byte is then loaded into the output register.
// Throughput: one input per cycle while each input makes a single byte and the
// receiver does not stall. An input that makes N bytes (escapes, CR-LF, fill or delay
// codes, up to eight spaces for a tab) sends them through the output register in turn.
// The front end keeps accepting while the two-entry descriptor queue has room.
// Reset (rst_n low at a clock edge) empties the queue, drops any pending output,
// clears the column and restores register defaults. When the receiver stalls,
// the output byte holds, the queue fills, and in_stall rises once it is full.
// Configuration writes are always ready; they should be issued while idle.
`timescale 1ns / 1ps

module tty_output_postprocessor_top
  import ttyop_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [3:0] cfg_data
);

  ttyop_cfg_t  cfg_r;
  ttyop_cfg_t  cfg_nxt;
  ttyop_desc_t front_desc;
  ttyop_desc_t q_head;
  logic        front_push_ok;
  logic        in_accept;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;

  // Configuration registers keep only the low bits of their width.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POST_ENABLE:  cfg_nxt.post_enable  = cfg_data[0];
        REG_CASE_MODE:    cfg_nxt.case_mode    = cfg_data[1:0];
        REG_NEWLINE_MODE: cfg_nxt.newline_mode = cfg_data;
        REG_FILL_MODE:    cfg_nxt.fill_mode    = cfg_data[1:0];
        REG_CR_DELAY:     cfg_nxt.cr_delay     = cfg_data[1:0];
        REG_TAB_DELAY:    cfg_nxt.tab_delay    = cfg_data[1:0];
        REG_MISC_DELAYS:  cfg_nxt.misc_delays  = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.post_enable  <= 1'b1;
      cfg_r.case_mode    <= 2'd0;
      cfg_r.newline_mode <= 4'd1;
      cfg_r.fill_mode    <= 2'd0;
      cfg_r.cr_delay     <= CRD_NONE;
      cfg_r.tab_delay    <= TABD_NONE;
      cfg_r.misc_delays  <= 4'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end accepts whenever the queue has a free slot.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;
  assign q_push    = in_accept && front_push_ok;

  ttyop_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .accept  (in_accept),
    .char_in (in_char_in),
    .push_ok (front_push_ok),
    .desc    (front_desc)
  );

  ttyop_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (front_desc),
    .pop   (q_pop),
    .dout  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  ttyop_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

`ifndef SYNTHESIS
  // A byte accepted in raw mode always leaves a descriptor in the queue.
  a_raw_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !cfg_r.post_enable |=> !q_empty)
    else $error("raw transaction did not reach the queue");

  // Retiring a descriptor loads the final byte of its run.
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid && out_last)
    else $error("descriptor retired without a final byte");

  // The input side only stalls when the queue holds work.
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !q_empty)
    else $error("input stalled with an empty queue");
`endif

endmodule

>>> hdl/ttyop_front.sv
// Front end: classifies each accepted byte, tracks the column and builds a run descriptor.
`timescale 1ns / 1ps

module ttyop_front
  import ttyop_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ttyop_cfg_t  cfg,
  input  logic        accept,
  input  logic [7:0]  char_in,
  output logic        push_ok,
  output ttyop_desc_t desc
);

  logic [7:0] column_r;
  logic [7:0] column_nxt;
  logic [7:0] c;
  logic [7:0] sent;
  logic [6:0] d;
  logic [6:0] cr_col_dly;
  logic [3:0] sp;
  logic [7:0] fill_byte;
  logic       do_cr;
  logic       do_nl;
  logic       expand;

  always_comb begin
    desc       = '0;
    push_ok    = 1'b1;
    column_nxt = column_r;
    c          = char_in;
    sent       = char_in;
    d          = '0;
    do_cr      = 1'b0;
    do_nl      = 1'b0;
    expand     = 1'b0;
    sp         = TAB_STOP - {1'b0, column_r[2:0]};
    cr_col_dly = '0;
    fill_byte  = cfg.fill_mode[1] ? CH_DEL : CH_NUL;

    if (!cfg.post_enable) begin
      desc.main_byte = char_in;
    end else if (char_in[7]) begin
      // The delay marker itself is doubled so the receiver can tell it apart.
      desc.pre_en    = (char_in == DELAY_MARK);
      desc.pre_byte  = DELAY_MARK;
      desc.main_byte = char_in;
    end else begin
      if (cfg.case_mode[1]) begin
        if (esc_hit(c)) begin
          desc.pre_en   = 1'b1;
          desc.pre_byte = CH_BSLASH;
          column_nxt    = column_nxt + 8'd1;
          c             = esc_map(c);
        end
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
          desc.pre_en   = 1'b1;
          desc.pre_byte = CH_BSLASH;
          column_nxt    = column_nxt + 8'd1;
        end
      end
      if (cfg.case_mode[0] && c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
        c = c - CASE_OFFSET;
      end
      sent = c;

      case (c)
        CH_BS: begin
          if (cfg.misc_delays[1]) begin
            d = DLY_BS;
          end
          if (column_nxt != 8'd0) begin
            column_nxt = column_nxt - 8'd1;
          end
        end
        CH_LF: begin
          if (cfg.newline_mode[3]) begin
            do_cr = 1'b1;
          end else if (cfg.newline_mode[0]) begin
            if (!(cfg.newline_mode[2] && column_nxt == 8'd0)) begin
              desc.pre_en   = 1'b1;
              desc.pre_byte = CH_CR;
            end
            do_cr = 1'b1;
          end else begin
            do_nl = 1'b1;
          end
        end
        CH_TAB: begin
          column_nxt = column_nxt + {4'd0, sp};
          case (cfg.tab_delay)
            TABD_COLUMN: d = (sp < TAB_MIN_DLY) ? 7'd0 : {3'd0, sp};
            TABD_FIXED:  d = DLY_TAB;
            TABD_EXPAND: expand = 1'b1;
            default:     d = '0;
          endcase
        end
        CH_VT: begin
          if (cfg.misc_delays[2]) begin
            d = DLY_PAGE;
          end
        end
        CH_CR: begin
          if (cfg.newline_mode[1]) begin
            sent  = CH_LF;
            do_nl = 1'b1;
          end else if (cfg.newline_mode[2] && column_nxt == 8'd0) begin
            push_ok = 1'b0;
          end else begin
            do_cr = 1'b1;
          end
        end
        CH_FF: begin
          if (cfg.misc_delays[3]) begin
            d = DLY_PAGE;
          end
        end
        default: begin
          if (c >= CH_SPACE && c < CH_DEL) begin
            column_nxt = column_nxt + 8'd1;
          end
        end
      endcase

      if (do_nl && cfg.misc_delays[0]) begin
        d = DLY_NL;
      end
      if (do_cr) begin
        cr_col_dly = {3'd0, column_nxt[7:4]} + DLY_CR_BASE;
        case (cfg.cr_delay)
          CRD_COLUMN: begin
            if (column_nxt != 8'd0) begin
              d = (cr_col_dly < DLY_CR_MIN) ? DLY_CR_MIN : cr_col_dly;
            end
          end
          CRD_SHORT: d = DLY_CR_SHORT;
          CRD_LONG:  d = DLY_CR_LONG;
          default:   d = d;
        endcase
        column_nxt = 8'd0;
      end

      if (expand) begin
        // Tab expansion sends only spaces, no tab byte and no delay.
        desc.main_byte = CH_SPACE;
        desc.main_rep  = 3'(sp - 4'd1);
      end else begin
        desc.main_byte = sent;
        if (d != 7'd0) begin
          if (d < DLY_FILL_MAX && cfg.fill_mode[0]) begin
            desc.suf_cnt = (d > DLY_ONE_FILL) ? 2'd2 : 2'd1;
            desc.suf0    = fill_byte;
            desc.suf1    = fill_byte;
          end else begin
            desc.suf_cnt = 2'd2;
            desc.suf0    = DELAY_MARK;
            desc.suf1    = {1'b1, d};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
    end else if (accept) begin
      column_r <= column_nxt;
    end
  end

endmodule

>>> hdl/ttyop_fifo.sv
// Short descriptor queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module ttyop_fifo
  import ttyop_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  ttyop_desc_t din,
  input  logic        pop,
  output ttyop_desc_t dout,
  output logic        full,
  output logic        empty
);

  ttyop_desc_t        mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic [Q_CNT_W-1:0] cnt_nxt;

  assign full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hdl/ttyop_back.sv
// Back end: feeds the output register one head-descriptor byte per unstalled cycle.
`timescale 1ns / 1ps

module ttyop_back
  import ttyop_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ttyop_desc_t head,
  input  logic        q_empty,
  output logic        q_pop,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  logic [2:0] idx_r;
  logic [2:0] idx_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       load;
  logic [3:0] idx;
  logic [3:0] n_pre;
  logic [3:0] end_main;
  logic [3:0] total;
  logic [7:0] cur_byte;
  logic       cur_last;

  assign idx      = {1'b0, idx_r};
  assign n_pre    = {3'd0, head.pre_en};
  assign end_main = n_pre + {1'b0, head.main_rep} + 4'd1;
  assign total    = end_main + {2'd0, head.suf_cnt};
  assign cur_last = (idx == total - 4'd1);

  always_comb begin
    if (idx < n_pre) begin
      cur_byte = head.pre_byte;
    end else if (idx < end_main) begin
      cur_byte = head.main_byte;
    end else if (idx == end_main) begin
      cur_byte = head.suf0;
    end else begin
      cur_byte = head.suf1;
    end
  end

  assign load          = !q_empty && (!out_valid_r || !out_stall);
  assign q_pop         = load && cur_last;
  assign out_valid_nxt = load || (out_valid_r && out_stall);
  assign idx_nxt       = !load ? idx_r : (cur_last ? 3'd0 : idx_r + 3'd1);

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= cur_byte;
      out_last_r <= cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule
